### rtl/core/mtf_pkg.sv
`default_nettype none

package mtf_pkg;

  // Width of a symbol and of a list position.
  localparam int unsigned SYM_W = 8;

  // Default number of entries in the symbol list.
  localparam int unsigned LIST_SIZE_DEF = 256;

  // Token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic             vld;
    logic             done;
    logic [SYM_W-1:0] carry;
    logic [SYM_W-1:0] res;
  } mtf_tok_t;

  // Signals that the controller drives into every cell.
  typedef struct packed {
    logic             decode;
    logic [SYM_W-1:0] key;
    logic             clear;
    logic             load;
    logic [SYM_W-1:0] load_val;
  } mtf_ctl_t;

endpackage

`default_nettype wire

### rtl/core/move_to_front_codec.sv
// Byte-wise move-to-front codec built as a chain of LIST_SIZE cells, each
// holding one list entry. An accepted item launches a token that walks the
// chain one cell per cycle, comparing and shifting entries as it passes. The
// token passes the launch register and every cell before its result is
// registered, and no new item is taken until the token has left the chain.
// In decode mode the found entry is written to the front cell when the token
// leaves the chain, and after an item flagged as last of a block all cells
// return to the identity at once. A finished result waits in the output
// register, while the next item may already be at work, or in a one-entry
// skid stage, which keeps intake closed. decode_mode is written through the
// configuration channel, which is always ready; write it only while idle.
`default_nettype none

module move_to_front_codec #(
  parameter int unsigned LIST_SIZE = mtf_pkg::LIST_SIZE_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire                          decode_mode_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [mtf_pkg::SYM_W-1:0]    symbol_in_i,
  input  wire                          block_last_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [mtf_pkg::SYM_W-1:0]    symbol_out_o,
  output logic                         block_last_out_o
);

  localparam int unsigned SW = mtf_pkg::SYM_W;
  localparam logic [SW-1:0] MISS_CODE = SW'(LIST_SIZE);
  localparam logic [SW-1:0] LAST_POS  = SW'(LIST_SIZE - 1);
  localparam logic [SW:0]   SIZE_EXT  = (SW+1)'(LIST_SIZE);

  logic              mode_q;
  logic              busy_q;
  logic              last_q;
  logic [SW-1:0]     key_q;
  mtf_pkg::mtf_tok_t launch_d, launch_q;

  logic              out_valid_q;
  logic [SW-1:0]     out_sym_q;
  logic              out_last_q;
  logic              pend_valid_q;
  logic [SW-1:0]     pend_sym_q;
  logic              pend_last_q;

  mtf_pkg::mtf_tok_t tok_s [LIST_SIZE+1];
  mtf_pkg::mtf_ctl_t ctl_s;
  mtf_pkg::mtf_ctl_t ctl_front;

  logic in_xfer;
  logic out_free;
  logic tok_exit;
  logic out_of_range;

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = busy_q | pend_valid_q;
  assign in_xfer      = in_valid_i & ~in_stall_o;
  assign out_free     = ~out_valid_q | ~out_stall_i;
  assign tok_exit     = tok_s[LIST_SIZE].vld;
  assign out_of_range = ({1'b0, symbol_in_i} >= SIZE_EXT);

  // Token for the front cell, issued the cycle after the input transfer.
  // In encode mode a byte outside the list is marked done, so the list stays unchanged.
  always_comb begin
    launch_d.vld   = in_xfer;
    launch_d.done  = ~mode_q & out_of_range;
    launch_d.carry = symbol_in_i;
    launch_d.res   = MISS_CODE;
  end

  assign ctl_s.decode   = mode_q;
  assign ctl_s.key      = key_q;
  assign ctl_s.clear    = tok_exit & last_q;
  assign ctl_s.load     = 1'b0;
  assign ctl_s.load_val = tok_s[LIST_SIZE].res;

  always_comb begin
    ctl_front      = ctl_s;
    ctl_front.load = tok_exit & mode_q & ~last_q;
  end

  assign tok_s[0] = launch_q;

  for (genvar k = 0; k < LIST_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_front
      mtf_cell #(.IDX(k)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .tok_i  (tok_s[k]),
        .ctl_i  (ctl_front),
        .tok_o  (tok_s[k+1])
      );
    end else begin : g_rest
      mtf_cell #(.IDX(k)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .tok_i  (tok_s[k]),
        .ctl_i  (ctl_s),
        .tok_o  (tok_s[k+1])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      busy_q       <= 1'b0;
      launch_q     <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= decode_mode_i;
      end
      launch_q <= launch_d;
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (tok_exit) begin
        busy_q <= 1'b0;
      end
      if (pend_valid_q && out_free) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (tok_exit) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      last_q <= block_last_i;
      if (mode_q) begin
        key_q <= out_of_range ? LAST_POS : symbol_in_i;
      end else begin
        key_q <= symbol_in_i;
      end
    end
    if (pend_valid_q && out_free) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= pend_last_q;
    end else if (tok_exit) begin
      if (out_free) begin
        out_sym_q  <= tok_s[LIST_SIZE].res;
        out_last_q <= last_q;
      end else begin
        pend_sym_q  <= tok_s[LIST_SIZE].res;
        pend_last_q <= last_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_out_o     = out_sym_q;
  assign block_last_out_o = out_last_q;

endmodule

`default_nettype wire

### rtl/core/mtf_cell.sv
`default_nettype none

module mtf_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mtf_pkg::mtf_tok_t    tok_i,
  input  mtf_pkg::mtf_ctl_t    ctl_i,
  output mtf_pkg::mtf_tok_t    tok_o
);

  localparam logic [mtf_pkg::SYM_W-1:0] MY_IDX = mtf_pkg::SYM_W'(IDX);

  logic [mtf_pkg::SYM_W-1:0] val_d, val_q;
  mtf_pkg::mtf_tok_t         tok_d, tok_q;

  always_comb begin
    val_d = val_q;
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (ctl_i.decode) begin
        // Entries ahead of the decoded position shift back by one. The front
        // cell keeps its value here; the controller rewrites it at the end.
        if (IDX != 0) begin
          val_d = tok_i.carry;
        end
        if (ctl_i.key == MY_IDX) begin
          tok_d.done = 1'b1;
          tok_d.res  = val_q;
        end else begin
          tok_d.carry = val_q;
        end
      end else begin
        // The carry starts as the input byte, so the front cell takes it.
        val_d = tok_i.carry;
        if (val_q == ctl_i.key) begin
          tok_d.done = 1'b1;
          tok_d.res  = MY_IDX;
        end else begin
          tok_d.carry = val_q;
        end
      end
    end
    if (ctl_i.clear) begin
      val_d = MY_IDX;
    end else if (ctl_i.load) begin
      val_d = ctl_i.load_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= MY_IDX;
      tok_q <= '0;
    end else begin
      val_q <= val_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

### rtl/core/mtf_checker.sv
`default_nettype none

module mtf_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_stall_o,
  input wire                       out_valid_o,
  input wire                       out_stall_i,
  input wire [mtf_pkg::SYM_W-1:0]  symbol_out_o,
  input wire                       block_last_out_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(symbol_out_o) && $stable(block_last_out_o))
    else $error("stalled result changed");

  // An item walks the whole chain, so intake closes after each transfer.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o ##1 in_stall_o)
    else $error("input taken while an item is at work");

  // A new item never produces a result in the cycle right after its transfer.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Intake stays closed while a skid entry could exist behind a stalled result.
  a_stall_while_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_xfer) && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("intake open with result stalled and item in flight");

endmodule

bind move_to_front_codec mtf_checker u_mtf_checker (.*);

`default_nettype wire
